/* src/teacbc_pkg.sv */
`default_nettype none

package teacbc_pkg;

  // Number of TEA rounds; every round is split over two half-round cells.
  localparam int unsigned Rounds   = 32;
  localparam int unsigned NumCells = 2 * Rounds;

  localparam logic [31:0] TeaDelta = 32'h9E37_79B9;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

  localparam int unsigned CfgIdxW = 8;

  // Configuration register map.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0 = 8'd0,
    CFG_KEY1 = 8'd1,
    CFG_KEY2 = 8'd2,
    CFG_KEY3 = 8'd3,
    CFG_DIR  = 8'd4
  } teacbc_reg_e;

  // Cipher direction codes.
  localparam logic DirEncrypt = 1'b0;
  localparam logic DirDecrypt = 1'b1;

  // Register contents seen by the cell row.
  typedef struct packed {
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic [31:0] key3;
    logic        dir;
  } teacbc_cfg_t;

  // One block in flight. The mix word is p and the updated word is q.
  // The chain words travel along for the decrypt output XOR.
  typedef struct packed {
    logic        valid;
    logic        dir;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] chain_lo;
    logic [31:0] chain_hi;
  } teacbc_slot_t;

endpackage

`default_nettype wire

/* src/teacbc_cfg.sv */
`default_nettype none

module teacbc_cfg import teacbc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output      teacbc_cfg_t        cfg_o
);

  teacbc_cfg_t cfg_q, cfg_d;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (teacbc_reg_e'(cfg_index_i))
        CFG_KEY0: cfg_d.key0 = cfg_data_i;
        CFG_KEY1: cfg_d.key1 = cfg_data_i;
        CFG_KEY2: cfg_d.key2 = cfg_data_i;
        CFG_KEY3: cfg_d.key3 = cfg_data_i;
        CFG_DIR:  cfg_d.dir  = cfg_data_i[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/teacbc_cell.sv */
`default_nettype none

module teacbc_cell import teacbc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         advance_i,
  input  wire logic         odd_i,
  input  wire logic [31:0]  sum_enc_i,
  input  wire logic [31:0]  sum_dec_i,
  input  wire teacbc_cfg_t  cfg_i,
  input  wire teacbc_slot_t slot_i,
  output      teacbc_slot_t slot_o
);

  logic         valid_q;
  teacbc_slot_t data_q, data_d;
  logic         use_hi;
  logic [31:0]  ka, kb, sum;
  logic [31:0]  shl_term, shr_term, sum_term, mix;

  // Key pair and round sum for this half-round.
  assign use_hi = slot_i.dir ^ odd_i;
  assign ka     = use_hi ? cfg_i.key2 : cfg_i.key0;
  assign kb     = use_hi ? cfg_i.key3 : cfg_i.key1;
  assign sum    = (slot_i.dir == DirDecrypt) ? sum_dec_i : sum_enc_i;

  // TEA mixing function on the p word.
  assign shl_term = (slot_i.p << 4) + ka;
  assign shr_term = (slot_i.p >> 5) + kb;
  assign sum_term = slot_i.p + sum;
  assign mix      = shl_term ^ sum_term ^ shr_term;

  // Update q, then swap so the next cell mixes from the fresh word.
  always_comb begin
    data_d   = slot_i;
    data_d.p = (slot_i.dir == DirDecrypt) ? (slot_i.q - mix) : (slot_i.q + mix);
    data_d.q = slot_i.p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    slot_o       = data_q;
    slot_o.valid = valid_q;
  end

endmodule

`default_nettype wire

/* src/tea_cbc_cipher_top.sv */
// TEA block cipher in CBC mode on 64-bit blocks.
// Input channel: in_valid_i / in_stall_o with word_low, word_high and
// first_block. A beat with first_block set restarts chaining from the
// all-ones IV. Output channel: out_valid_o / out_stall_i with out_low and
// out_high, one result beat per input beat, in order.
// Configuration: cfg_valid_i / cfg_ready_o writes key words 0 to 3 at
// indexes 0 to 3 and the direction at index 4; write only while idle.
// The rounds run down a row of 64 half-round cells, one cell per cycle
// while the row advances; the last cell feeds the output register.
// Decryption beats can enter every cycle unless the row is frozen. An
// encryption beat needs the previous ciphertext as its chain, so after an
// encryption beat the input stalls until that block leaves the cell row.
// When out_stall_i holds a result, the row keeps moving into empty slots
// and freezes only once the last cell holds a block.
// Reset clears the keys, selects encryption, loads the all-ones chain and
// empties the cell row.
`default_nettype none

module tea_cbc_cipher_top import teacbc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [31:0]        word_low_i,
  input  wire logic [31:0]        word_high_i,
  input  wire logic               first_block_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [31:0]        out_low_o,
  output      logic [31:0]        out_high_o
);

  teacbc_cfg_t  cfg;
  teacbc_slot_t stage [NumCells+1];
  teacbc_slot_t entry;
  teacbc_slot_t last;
  logic         advance, accept, retire, enc_retire;
  logic         pending_q, pending_d;
  logic [31:0]  chain_lo_q, chain_lo_d, chain_hi_q, chain_hi_d;
  logic [31:0]  iv_lo, iv_hi;
  logic [31:0]  res_lo, res_hi;
  logic         out_valid_q;
  logic [31:0]  out_lo_q, out_hi_q;

  teacbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The row moves unless a finished block sits in the last cell and the
  // output register is full and stalled.
  assign last       = stage[NumCells];
  assign advance    = !last.valid || !out_valid_q || !out_stall_i;
  assign in_stall_o = pending_q || !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign retire     = advance && last.valid;
  assign enc_retire = retire && (last.dir == DirEncrypt);

  // Chain value used by the beat being accepted.
  assign iv_lo = first_block_i ? AllOnes : chain_lo_q;
  assign iv_hi = first_block_i ? AllOnes : chain_hi_q;

  // Entry into the first cell: encryption whitens with the chain first.
  always_comb begin
    entry          = '0;
    entry.valid    = accept;
    entry.dir      = cfg.dir;
    entry.chain_lo = iv_lo;
    entry.chain_hi = iv_hi;
    if (cfg.dir == DirDecrypt) begin
      entry.p = word_low_i;
      entry.q = word_high_i;
    end else begin
      entry.p = word_high_i ^ iv_hi;
      entry.q = word_low_i ^ iv_lo;
    end
  end

  assign stage[0] = entry;

  // Row of half-round cells with their fixed round sums.
  for (genvar h = 0; h < NumCells; h++) begin : g_cell
    localparam int unsigned Rnd     = h / 2;
    localparam logic [63:0] EncProd = 64'(TeaDelta) * 64'(Rnd + 1);
    localparam logic [63:0] DecProd = 64'(TeaDelta) * 64'(Rounds - Rnd);

    teacbc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .odd_i     (1'(h % 2)),
      .sum_enc_i (EncProd[31:0]),
      .sum_dec_i (DecProd[31:0]),
      .cfg_i     (cfg),
      .slot_i    (stage[h]),
      .slot_o    (stage[h+1])
    );
  end

  // Words leaving the row; decryption unwhitens with the carried chain.
  always_comb begin
    if (last.dir == DirDecrypt) begin
      res_lo = last.p ^ last.chain_lo;
      res_hi = last.q ^ last.chain_hi;
    end else begin
      res_lo = last.q;
      res_hi = last.p;
    end
  end

  // Chain and pending encryption tracking.
  always_comb begin
    chain_lo_d = chain_lo_q;
    chain_hi_d = chain_hi_q;
    pending_d  = pending_q;
    if (enc_retire) begin
      chain_lo_d = res_lo;
      chain_hi_d = res_hi;
      pending_d  = 1'b0;
    end
    if (accept) begin
      if (cfg.dir == DirDecrypt) begin
        chain_lo_d = word_low_i;
        chain_hi_d = word_high_i;
      end else begin
        pending_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      chain_lo_q <= AllOnes;
      chain_hi_q <= AllOnes;
    end else begin
      pending_q  <= pending_d;
      chain_lo_q <= chain_lo_d;
      chain_hi_q <= chain_hi_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (retire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_lo_q <= res_lo;
      out_hi_q <= res_hi;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_low_o   = out_lo_q;
  assign out_high_o  = out_hi_q;

endmodule

`default_nettype wire

/* src/teacbc_checker.sv */
`default_nettype none

module teacbc_checker import teacbc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [CfgIdxW-1:0] cfg_index_i,
  input wire logic [31:0]        cfg_data_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [31:0]        word_low_i,
  input wire logic [31:0]        word_high_i,
  input wire logic               first_block_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [31:0]        out_low_o,
  input wire logic [31:0]        out_high_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_low_o) && $stable(out_high_o))
    else $error("result data changed while stalled");

  // The register port never pushes back.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // Leaving reset, no result can be offered yet.
  a_reset_empty: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind tea_cbc_cipher_top teacbc_checker u_teacbc_checker (.*);

`default_nettype wire

/* dv/tea_cbc_cipher_checker.sv */
module tea_cbc_cipher_checker import teacbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        word_low_i,
  input  logic [31:0]        word_high_i,
  input  logic               first_block_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        out_low_i,
  input  logic [31:0]        out_high_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } block_t;

  // Shadow copy of the registers and of the chaining value.
  teacbc_cfg_t regs_q;
  logic [31:0] chain_lo_q;
  logic [31:0] chain_hi_q;

  // Cipher or plain blocks still owed by the block, oldest first.
  block_t      owed_blocks[$];

  // One TEA half-round mixing term.
  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  function automatic block_t tea_encipher(input block_t blk, input teacbc_cfg_t k);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    int          r;
    v0  = blk.lo;
    v1  = blk.hi;
    sum = '0;
    for (r = 0; r < Rounds; r++) begin
      sum += TeaDelta;
      v0  += tea_mix(v1, sum, k.key0, k.key1);
      v1  += tea_mix(v0, sum, k.key2, k.key3);
    end
    return '{lo: v0, hi: v1};
  endfunction

  // Decryption walks the round sum down from DELTA times the round count.
  function automatic block_t tea_decipher(input block_t blk, input teacbc_cfg_t k);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    int          r;
    v0  = blk.lo;
    v1  = blk.hi;
    sum = 32'(TeaDelta * Rounds);
    for (r = 0; r < Rounds; r++) begin
      v1  -= tea_mix(v0, sum, k.key2, k.key3);
      v0  -= tea_mix(v1, sum, k.key0, k.key1);
      sum -= TeaDelta;
    end
    return '{lo: v0, hi: v1};
  endfunction

  // Works out the result of one input beat and advances the chain.
  function automatic block_t cbc_predict(input logic [31:0] word_lo, input logic [31:0] word_hi,
                                         input logic restart);
    block_t res;
    if (restart) begin
      chain_lo_q = AllOnes;
      chain_hi_q = AllOnes;
    end
    if (regs_q.dir == DirEncrypt) begin
      res = tea_encipher('{lo: word_lo ^ chain_lo_q, hi: word_hi ^ chain_hi_q}, regs_q);
      chain_lo_q = res.lo;
      chain_hi_q = res.hi;
    end else begin
      res = tea_decipher('{lo: word_lo, hi: word_hi}, regs_q);
      res.lo ^= chain_lo_q;
      res.hi ^= chain_hi_q;
      chain_lo_q = word_lo;
      chain_hi_q = word_hi;
    end
    return res;
  endfunction

  // Track register writes, predict on input beats, compare on output beats.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    block_t want;
    if (!rst_ni) begin
      regs_q       = '0;
      regs_q.dir   = DirEncrypt;
      chain_lo_q   = AllOnes;
      chain_hi_q   = AllOnes;
      owed_blocks.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KEY0: regs_q.key0 = cfg_data_i;
          CFG_KEY1: regs_q.key1 = cfg_data_i;
          CFG_KEY2: regs_q.key2 = cfg_data_i;
          CFG_KEY3: regs_q.key3 = cfg_data_i;
          CFG_DIR:  regs_q.dir  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        owed_blocks.push_back(cbc_predict(word_low_i, word_high_i, first_block_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_blocks.size() == 0) begin
          $error("output beat with no block owed: out_low %08h out_high %08h",
                 out_low_i, out_high_i);
          fail_count_o++;
        end else begin
          want = owed_blocks.pop_front();
          if (out_low_i !== want.lo) begin
            $error("out_low: expected %08h, got %08h", want.lo, out_low_i);
            fail_count_o++;
          end
          if (out_high_i !== want.hi) begin
            $error("out_high: expected %08h, got %08h", want.hi, out_high_i);
            fail_count_o++;
          end
        end
      end
      pending_o = owed_blocks.size();
    end
  end

endmodule

/* dv/tb_tea_cbc_cipher_top.sv */
module tb_tea_cbc_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import teacbc_pkg::*;

  localparam int unsigned RandomItems  = 935;
  localparam int unsigned TailItems    = 150;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned CfgIdxTop    = (1 << CfgIdxW) - 1;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [31:0]        cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [31:0]        word_low    = '0;
  logic [31:0]        word_high   = '0;
  logic               first_block = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [31:0]        out_low;
  logic [31:0]        out_high;

  int unsigned        blocks_owed;
  int unsigned        fail_count;
  int unsigned        quiet_cycles = 0;

  // Chance of a gap before a beat, or of a stall burst starting: 0 means none, else one in N.
  int unsigned        gap_odds   = 0;
  int unsigned        stall_odds = 0;

  always #1 clk = ~clk;

  tea_cbc_cipher_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .word_low_i    (word_low),
    .word_high_i   (word_high),
    .first_block_i (first_block),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_low_o     (out_low),
    .out_high_o    (out_high)
  );

  tea_cbc_cipher_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .word_low_i    (word_low),
    .word_high_i   (word_high),
    .first_block_i (first_block),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_low_i     (out_low),
    .out_high_i    (out_high),
    .pending_o     (blocks_owed),
    .fail_count_o  (fail_count)
  );

  // Receiver back-pressure comes in random bursts.
  always begin : out_stall_gen
    @(posedge clk);
    if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // End the run if no beat moves on any channel for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Biased word: extremes now and then, otherwise anything.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AllOnes;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 5;
      default: return 12;
    endcase
  endfunction

  // Returns at a rising edge once every owed block has come out.
  task automatic drain();
    @(negedge clk);
    while (blocks_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Holds one register write until it is taken; leaves valid high.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Waits for the block to go idle, then writes all five registers and, if asked, one stray index.
  task automatic apply_setup(input teacbc_cfg_t setup, input logic [30:0] dir_pad,
                             input bit stray);
    drain();
    write_reg(CFG_KEY0, setup.key0);
    write_reg(CFG_KEY1, setup.key1);
    write_reg(CFG_KEY2, setup.key2);
    write_reg(CFG_KEY3, setup.key3);
    write_reg(CFG_DIR, {dir_pad, setup.dir});
    if (stray) begin
      write_reg(CfgIdxW'($urandom_range(int'(CFG_DIR) + 1, CfgIdxTop)), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one input beat, with an optional gap ahead of it.
  task automatic send_block(input logic [31:0] lo, input logic [31:0] hi, input logic restart);
    logic taken;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    word_low    <= lo;
    word_high   <= hi;
    first_block <= restart;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin : stimulus
    teacbc_cfg_t setup;
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned hold_at;
    int unsigned msg_left;
    int unsigned j;
    logic        restart;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero key, encryption, chain at the all-ones IV.
    send_block('0, '0, 1'b0);
    send_block(AllOnes, AllOnes, 1'b0);
    send_block(32'h0000_0001, 32'h8000_0000, 1'b1);
    in_valid <= 1'b0;

    // All-ones key, plus a write to an index with no register behind it.
    setup = '{key0: AllOnes, key1: AllOnes, key2: AllOnes, key3: AllOnes, dir: DirEncrypt};
    apply_setup(setup, '0, 1'b1);
    send_block('0, '0, 1'b1);
    send_block(AllOnes, AllOnes, 1'b0);
    send_block($urandom, $urandom, 1'b0);
    in_valid <= 1'b0;

    // Switch to decryption mid-message: the chain carries over.
    setup.dir = DirDecrypt;
    apply_setup(setup, '1, 1'b0);
    send_block($urandom, $urandom, 1'b0);
    send_block(AllOnes, AllOnes, 1'b0);
    send_block('0, '0, 1'b1);
    send_block('0, '0, 1'b0);
    in_valid <= 1'b0;

    // Mixed extreme key words, encryption with the upper direction bits set.
    setup = '{key0: '0, key1: AllOnes, key2: 32'h8000_0000, key3: 32'h0000_0001,
              dir: DirEncrypt};
    apply_setup(setup, '1, 1'b0);
    send_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_block($urandom, $urandom, 1'b0);
    in_valid <= 1'b0;

    setup.dir = DirDecrypt;
    apply_setup(setup, '0, 1'b0);
    send_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_block($urandom, $urandom, 1'b1);
    in_valid <= 1'b0;

    // Random phases: fresh settings each, then messages of random blocks.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      setup = '{key0: pick_word(), key1: pick_word(), key2: pick_word(),
                key3: pick_word(), dir: logic'($urandom_range(0, 1))};
      apply_setup(setup, 31'($urandom), $urandom_range(0, 2) == 0);
      if (sent + TailItems >= RandomItems) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end
      phase_len = $urandom_range(10, 60);
      hold_at   = (phase == 0 || $urandom_range(0, 7) == 0) ?
                  $urandom_range(1, phase_len - 1) : phase_len;
      // Sometimes the phase keeps the chain left by the previous one.
      msg_left  = $urandom_range(0, 6);
      for (j = 0; j < phase_len; j++) begin
        // Sender pause until every owed block is out.
        if (j == hold_at) begin
          in_valid <= 1'b0;
          drain();
        end
        if (msg_left == 0) begin
          restart  = $urandom_range(0, 9) != 0;
          msg_left = $urandom_range(1, 12);
        end else begin
          restart  = $urandom_range(0, 19) == 0;
          msg_left--;
        end
        send_block(pick_word(), pick_word(), restart);
        sent++;
      end
      in_valid <= 1'b0;
      phase++;
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/teacbc_pkg.sv
src/teacbc_cfg.sv
src/teacbc_cell.sv
src/tea_cbc_cipher_top.sv
src/teacbc_checker.sv
dv/tea_cbc_cipher_checker.sv
dv/tb_tea_cbc_cipher_top.sv
